@@ hw/rtl/vp8dpk_pkg.sv @@
// Shared types and constants for the VP8 RTP depacketizer.
// Depends on nothing; imported by vp8_rtp_depacketizer.
package vp8dpk_pkg;

   // Default frame buffer size in bytes.
   localparam int MAX_FRAME_BYTES_DEF = 16384;

   // Payload descriptor bit masks.
   localparam logic [7:0] DESC_X_MASK   = 8'h80;  // first byte: extension present
   localparam logic [7:0] DESC_S_MASK   = 8'h10;  // first byte: start of partition
   localparam logic [7:0] DESC_PID_MASK = 8'h07;  // first byte: partition index
   localparam logic [7:0] EXT_I_MASK    = 8'h80;  // extension: picture id present
   localparam logic [7:0] EXT_L_MASK    = 8'h40;  // extension: TL0PICIDX present
   localparam logic [7:0] EXT_TK_MASK   = 8'h30;  // extension: TID/KEYIDX present
   localparam logic [7:0] PID_M_MASK    = 8'h80;  // picture id: two-byte form
   localparam logic [7:0] KEY_BIT_MASK  = 8'h01;  // frame byte 0: inverse key flag

   // Function codes of an input item.
   typedef enum logic {
      FUNC_PAYLOAD = 1'b0,
      FUNC_READ    = 1'b1
   } func_type;

   // Result status codes.
   typedef enum logic [2:0] {
      ST_READ_DATA   = 3'd0,
      ST_APPENDED    = 3'd1,
      ST_COMPLETE    = 3'd2,
      ST_BAD_DESC    = 3'd3,
      ST_NOT_IN_FRAME = 3'd4,
      ST_OVERFLOW    = 3'd5
   } status_type;

endpackage

@@ hw/rtl/vp8dpk_ram.sv @@
// Generic single-port RAM with one write or read per cycle and a registered read.
// Depends on nothing; used for the depacketizer frame buffer.
module vp8dpk_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      // The read register only changes on a read, so its data holds otherwise.
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/vp8_rtp_depacketizer.sv @@
// Top level of the VP8 RTP depacketizer: descriptor parse, frame assembly, result path.
// Depends on vp8dpk_pkg and on vp8dpk_ram for the frame buffer.
//
// This block takes RTP VP8 payload bytes, one item per clock, and assembles the data
// bytes of each frame into an on-chip frame buffer of MAX_FRAME_BYTES bytes. An item
// is either a payload byte (func 0) with packet start, packet end and marker flags,
// or a read of one frame buffer byte (func 1). The block sustains one item per
// cycle while req_stall is low: the whole descriptor parse and the buffer write for
// a byte happen in the cycle the item is accepted, and the single buffer port serves
// either that write or a read. A result appears for every read and for every packet
// end; it passes stage 1, while the buffer read is registered inside the memory, and
// then the output register, from which it drives the rsp_ ports. A
// second result can wait in the stage ahead of the output register, so the input
// keeps flowing while the output side stalls; only when both hold results and the
// output is stalled does req_stall rise. The buffer is not cleared after reset and
// needs no clearing pass; reading a byte that was never written returns an
// undefined value. Addresses at or beyond MAX_FRAME_BYTES read as zero.
module vp8_rtp_depacketizer #(
   parameter int MAX_FRAME_BYTES = vp8dpk_pkg::MAX_FRAME_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // Input channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [7:0]  req_data_byte,
   input  logic        req_packet_first,
   input  logic        req_packet_last,
   input  logic        req_rtp_marker,
   input  logic [13:0] req_read_address,
   // Result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_read_byte,
   output logic [14:0] rsp_frame_length,
   output logic        rsp_keyframe
);
   import vp8dpk_pkg::*;

   // Address width of the buffer, width of the assembled length (0..MAX), width of
   // the per-packet data count (0..MAX+1, it saturates there) and of their sum.
   localparam int AW    = $clog2(MAX_FRAME_BYTES);
   localparam int LEN_W = $clog2(MAX_FRAME_BYTES + 1);
   localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 2);
   localparam int SUM_W = CNT_W + 1;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FRAME_BYTES);
   localparam logic [SUM_W-1:0] MAX_SUM = SUM_W'(MAX_FRAME_BYTES);

   // ------------------------------------------------------------------------
   // Parser and frame state.
   // ------------------------------------------------------------------------
   logic [LEN_W-1:0] asm_len_ff, asm_len_in;
   logic             frame_open_ff, frame_open_in;
   logic [2:0]       idx_ff, idx_in;
   logic [2:0]       desc_len_ff, desc_len_in;
   logic [7:0]       desc_first_ff, desc_first_in;
   logic [7:0]       ext_bits_ff, ext_bits_in;
   logic [CNT_W-1:0] data_cnt_ff, data_cnt_in;
   logic             key_bit_ff, key_bit_in;

   // Result stage 1 (waits for the buffer read data) and output register.
   logic             s1_valid_ff, s1_valid_in;
   status_type       s1_status_ff, s1_status_in;
   logic [14:0]      s1_len_ff, s1_len_in;
   logic             s1_key_ff, s1_key_in;
   logic             s1_rd_ok_ff, s1_rd_ok_in;

   logic             s2_valid_ff;
   logic [2:0]       s2_status_ff;
   logic [7:0]       s2_byte_ff;
   logic [14:0]      s2_len_ff;
   logic             s2_key_ff;

   // Handshake.
   logic             accept;
   logic             s1_move;
   logic             is_read;

   // Buffer port.
   logic             ram_wr_en;
   logic             ram_rd_en;
   logic [AW-1:0]    ram_addr;
   logic [7:0]       ram_rd_data;

   // Datapath intermediates.
   logic [2:0]       e_idx;
   logic [2:0]       e_desc_len;
   logic [7:0]       e_desc_first;
   logic [7:0]       e_ext_bits;
   logic [CNT_W-1:0] e_data_cnt;
   logic             is_data;
   logic             frame_start;
   logic [SUM_W-1:0] wr_pos;
   logic [SUM_W-1:0] commit_sum;
   logic [31:0]      rd_addr_wide;
   logic             rd_in_range;
   logic [31:0]      len_wide;
   logic             result_now;
   status_type       result_status;
   logic             result_key;

   // The output register moves whenever it is empty or its result is taken; stage 1
   // moves into it then, and the input may be taken whenever stage 1 is free or moving.
   assign s1_move   = !s2_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !s1_move;
   assign accept    = req_valid && !req_stall;
   assign is_read   = (req_func == FUNC_READ);

   assign rd_addr_wide = 32'(req_read_address);
   assign rd_in_range  = rd_addr_wide < 32'(MAX_FRAME_BYTES);

   // ------------------------------------------------------------------------
   // Descriptor parse and frame assembly for one payload byte.
   // ------------------------------------------------------------------------
   always_comb begin
      // A packet start discards whatever remained of the previous packet.
      if (req_packet_first) begin
         e_idx        = 3'd0;
         e_desc_len   = 3'd1;
         e_desc_first = 8'h00;
         e_ext_bits   = 8'h00;
         e_data_cnt   = '0;
      end else begin
         e_idx        = idx_ff;
         e_desc_len   = desc_len_ff;
         e_desc_first = desc_first_ff;
         e_ext_bits   = ext_bits_ff;
         e_data_cnt   = data_cnt_ff;
      end

      desc_first_in = e_desc_first;
      ext_bits_in   = e_ext_bits;
      desc_len_in   = e_desc_len;

      // Descriptor length grows as the first byte, the extension byte and the
      // picture id's first byte reveal which optional fields follow.
      if (e_idx == 3'd0) begin
         desc_first_in = req_data_byte;
         desc_len_in   = ((req_data_byte & DESC_X_MASK) != 8'h00) ? 3'd2 : 3'd1;
      end else if (e_idx == 3'd1 && (e_desc_first & DESC_X_MASK) != 8'h00) begin
         ext_bits_in = req_data_byte;
         desc_len_in = 3'd2
                     + {2'b00, (req_data_byte & EXT_I_MASK) != 8'h00}
                     + {2'b00, (req_data_byte & EXT_L_MASK) != 8'h00}
                     + {2'b00, (req_data_byte & EXT_TK_MASK) != 8'h00};
      end else if (e_idx == 3'd2 && (e_desc_first & DESC_X_MASK) != 8'h00
                   && (e_ext_bits & EXT_I_MASK) != 8'h00) begin
         if ((req_data_byte & PID_M_MASK) != 8'h00) begin
            desc_len_in = e_desc_len + 3'd1;
         end
      end

      is_data = e_idx >= desc_len_in;

      // A partition-0 start at the packet's first data byte opens a new frame.
      frame_start = is_data && (e_data_cnt == '0)
                 && (desc_first_in & DESC_S_MASK) != 8'h00
                 && (desc_first_in & DESC_PID_MASK) == 8'h00;

      asm_len_in    = frame_start ? '0 : asm_len_ff;
      frame_open_in = frame_start ? 1'b1 : frame_open_ff;

      wr_pos     = SUM_W'(asm_len_in) + SUM_W'(e_data_cnt);
      ram_wr_en  = accept && !is_read && is_data && frame_open_in && (wr_pos < MAX_SUM);
      key_bit_in = key_bit_ff;
      if (ram_wr_en && wr_pos == '0) begin
         key_bit_in = req_data_byte[0];
      end

      data_cnt_in = e_data_cnt;
      if (is_data && e_data_cnt <= MAX_CNT) begin
         data_cnt_in = e_data_cnt + 1'b1;
      end
      idx_in = (e_idx == 3'd7) ? e_idx : e_idx + 3'd1;

      // Packet end: commit, drop or report, then clear the packet state.
      commit_sum    = SUM_W'(asm_len_in) + SUM_W'(data_cnt_in);
      result_now    = req_packet_last;
      result_key    = 1'b0;
      result_status = ST_APPENDED;
      if (req_packet_last) begin
         if (data_cnt_in == '0) begin
            result_status = ST_BAD_DESC;
         end else if (!frame_open_in) begin
            result_status = ST_NOT_IN_FRAME;
         end else if (commit_sum > MAX_SUM) begin
            result_status = ST_OVERFLOW;
            frame_open_in = 1'b0;
            asm_len_in    = '0;
         end else begin
            asm_len_in = LEN_W'(commit_sum);
            if (req_rtp_marker) begin
               result_status = ST_COMPLETE;
               frame_open_in = 1'b0;
               result_key    = (key_bit_in & KEY_BIT_MASK[0]) == 1'b0;
            end
         end
         idx_in        = 3'd0;
         desc_len_in   = 3'd1;
         desc_first_in = 8'h00;
         ext_bits_in   = 8'h00;
         data_cnt_in   = '0;
      end

      // A read reports the unchanged state.
      if (is_read) begin
         asm_len_in    = asm_len_ff;
         frame_open_in = frame_open_ff;
         idx_in        = idx_ff;
         desc_len_in   = desc_len_ff;
         desc_first_in = desc_first_ff;
         ext_bits_in   = ext_bits_ff;
         data_cnt_in   = data_cnt_ff;
         key_bit_in    = key_bit_ff;
         result_now    = 1'b1;
         result_status = ST_READ_DATA;
         result_key    = 1'b0;
      end
   end

   assign ram_rd_en = accept && is_read && rd_in_range;
   assign ram_addr  = is_read ? rd_addr_wide[AW-1:0] : wr_pos[AW-1:0];
   assign len_wide  = 32'(asm_len_in);

   // Stage 1 load/hold.
   always_comb begin
      s1_valid_in  = s1_valid_ff && !s1_move;
      s1_status_in = s1_status_ff;
      s1_len_in    = s1_len_ff;
      s1_key_in    = s1_key_ff;
      s1_rd_ok_in  = s1_rd_ok_ff;
      if (accept && result_now) begin
         s1_valid_in  = 1'b1;
         s1_status_in = result_status;
         s1_len_in    = len_wide[14:0];
         s1_key_in    = result_key;
         s1_rd_ok_in  = is_read && rd_in_range;
      end
   end

   vp8dpk_ram #(
      .WIDTH (8),
      .DEPTH (MAX_FRAME_BYTES)
   ) u_frame_buffer (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .rd_en   (ram_rd_en),
      .addr    (ram_addr),
      .wr_data (req_data_byte),
      .rd_data (ram_rd_data)
   );

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         asm_len_ff    <= '0;
         frame_open_ff <= 1'b0;
         idx_ff        <= 3'd0;
         desc_len_ff   <= 3'd1;
         desc_first_ff <= 8'h00;
         ext_bits_ff   <= 8'h00;
         data_cnt_ff   <= '0;
         key_bit_ff    <= 1'b0;
      end else if (accept) begin
         asm_len_ff    <= asm_len_in;
         frame_open_ff <= frame_open_in;
         idx_ff        <= idx_in;
         desc_len_ff   <= desc_len_in;
         desc_first_ff <= desc_first_in;
         ext_bits_ff   <= ext_bits_in;
         data_cnt_ff   <= data_cnt_in;
         key_bit_ff    <= key_bit_in;
      end
   end

   // Result stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (s1_move) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_status_ff <= s1_status_in;
      s1_len_ff    <= s1_len_in;
      s1_key_ff    <= s1_key_in;
      s1_rd_ok_ff  <= s1_rd_ok_in;
      if (s1_move && s1_valid_ff) begin
         s2_status_ff <= s1_status_ff;
         s2_byte_ff   <= s1_rd_ok_ff ? ram_rd_data : 8'h00;
         s2_len_ff    <= s1_len_ff;
         s2_key_ff    <= s1_key_ff;
      end
   end

   assign rsp_valid        = s2_valid_ff;
   assign rsp_status       = s2_status_ff;
   assign rsp_read_byte    = s2_byte_ff;
   assign rsp_frame_length = s2_len_ff;
   assign rsp_keyframe     = s2_key_ff;

   // ------------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------------
   a_asm_bound: assert property (@(posedge clock) disable iff (reset)
      32'(asm_len_ff) <= 32'(MAX_FRAME_BYTES))
      else $error("assembled length exceeds the frame buffer");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      32'(data_cnt_ff) <= 32'(MAX_FRAME_BYTES) + 32'd1)
      else $error("packet data count passed its saturation value");

   a_overflow_drop: assert property (@(posedge clock) disable iff (reset)
      accept && result_now && result_status == ST_OVERFLOW
      |=> !frame_open_ff && asm_len_ff == '0)
      else $error("overflow did not drop the frame");

   // The read data only matters, and is only defined, for a waiting read.
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_move |=> s1_valid_ff && $stable(s1_status_ff)
                                  && (!s1_rd_ok_ff || $stable(ram_rd_data)))
      else $error("waiting result or its read data changed");

   a_read_no_write: assert property (@(posedge clock) disable iff (reset)
      !(ram_wr_en && ram_rd_en))
      else $error("buffer port asked to read and write together");

endmodule
